// ===== rtl/sliding_window_kth_smallest_unit_assert.svh =====
// Assertion macros shared by the rank-order filter.
`ifndef SLIDING_WINDOW_KTH_SMALLEST_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_KTH_SMALLEST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWKS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWKS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/swks_pkg.sv =====
// Types and constants of the sliding window rank-order filter.
`timescale 1ns / 1ps

package swks_pkg;

   // Sizes of the window and of the fields.
   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int AGE_WIDTH    = $clog2(MAX_WINDOW);
   localparam int PTR_WIDTH    = $clog2(MAX_WINDOW);
   localparam int LEN_WIDTH    = 7;
   localparam int RANK_WIDTH   = 7;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [AGE_WIDTH-1:0]           age_type;
   typedef logic [LEN_WIDTH-1:0]           len_type;
   typedef logic [RANK_WIDTH-1:0]          rank_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_LAUNCH = 5'b00100,
      ST_QUERY  = 5'b01000,
      ST_DRAIN  = 5'b10000
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic       update;
      logic       evict;
      sample_type new_value;
      sample_type old_value;
      len_type    len;
   } cell_ctrl_type;

   // What a cell shows to its neighbours.
   typedef struct packed {
      logic       valid;
      sample_type value;
      age_type    age;
      logic       above_new;
      logic       at_or_above_old;
   } cell_view_type;

   // Query token walking along the row.
   typedef struct packed {
      logic       valid;
      rank_type   count;
      logic       found;
      sample_type value;
   } token_type;

   // Neighbour views beyond the two ends of the row.
   localparam cell_view_type VIEW_LEFT_EDGE = '{
      valid: 1'b0, value: '0, age: '0, above_new: 1'b0, at_or_above_old: 1'b0
   };
   localparam cell_view_type VIEW_RIGHT_EDGE = '{
      valid: 1'b0, value: '0, age: '0, above_new: 1'b1, at_or_above_old: 1'b1
   };

endpackage

// ===== rtl/swks_req_if.sv =====
// Input channel: one sample and one rank per transaction.
`timescale 1ns / 1ps

interface swks_req_if;
   logic                 valid;
   logic                 ready;
   swks_pkg::sample_type sample_value;
   swks_pkg::rank_type   rank;

   modport source (output valid, output sample_value, output rank, input ready);
   modport sink   (input valid, input sample_value, input rank, output ready);
endinterface

// ===== rtl/swks_rsp_if.sv =====
// Result channel: the selected sample and the invalid-rank flag.
`timescale 1ns / 1ps

interface swks_rsp_if;
   logic                 valid;
   logic                 ready;
   swks_pkg::sample_type kth_value;
   logic                 rank_invalid;

   modport source (output valid, output kth_value, output rank_invalid, input ready);
   modport sink   (input valid, input kth_value, input rank_invalid, output ready);
endinterface

// ===== rtl/swks_csr_if.sv =====
// Configuration write channel carrying the window length.
`timescale 1ns / 1ps

interface swks_csr_if;
   logic              valid;
   logic              ready;
   swks_pkg::len_type window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

// ===== rtl/swks_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module swks_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swks_cell.sv =====
// One cell of the sorted row: holds one sample and its age, and passes the query token on.
`timescale 1ns / 1ps

module swks_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  swks_pkg::cell_ctrl_type  ctrl,
   input  swks_pkg::cell_view_type  left_view,
   input  swks_pkg::cell_view_type  right_view,
   output swks_pkg::cell_view_type  own_view,
   input  swks_pkg::token_type      token_in,
   output swks_pkg::token_type      token_out
);

   logic                 valid_ff, valid_in;
   swks_pkg::sample_type value_ff, value_in;
   swks_pkg::age_type    age_ff, age_in;
   swks_pkg::token_type  token_ff, token_in_next;

   logic above_new;
   logic at_or_above_old;
   logic take_left;
   logic take_new;
   logic take_right;
   logic in_window;

   // The row is sorted ascending with the oldest first among equals. An empty cell
   // sorts above every sample; the evicted sample is the first one not below the
   // oldest value.
   assign above_new       = !valid_ff || ($signed(value_ff) > $signed(ctrl.new_value));
   assign at_or_above_old = ctrl.evict && valid_ff &&
                            ($signed(value_ff) >= $signed(ctrl.old_value));

   assign own_view = '{
      valid: valid_ff, value: value_ff, age: age_ff,
      above_new: above_new, at_or_above_old: at_or_above_old
   };

   // Source selection for removing the oldest sample and inserting the new one
   // in the same cycle.
   assign take_left  = left_view.above_new && !left_view.at_or_above_old;
   assign take_new   = (above_new && !left_view.above_new && !left_view.at_or_above_old) ||
                       (right_view.above_new && !above_new && at_or_above_old);
   assign take_right = at_or_above_old && !right_view.above_new;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff + 1'b1;
      if (take_left) begin
         valid_in = left_view.valid;
         value_in = left_view.value;
         age_in   = left_view.age + 1'b1;
      end else if (take_new) begin
         valid_in = 1'b1;
         value_in = ctrl.new_value;
         age_in   = '0;
      end else if (take_right) begin
         valid_in = right_view.valid;
         value_in = right_view.value;
         age_in   = right_view.age + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.update) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   // Token step: count down over samples inside the window and pick up the value
   // at which the count runs out.
   assign in_window = valid_ff && (swks_pkg::LEN_WIDTH'(age_ff) < ctrl.len);

   always_comb begin
      token_in_next = token_in;
      if (token_in.valid && !token_in.found && in_window) begin
         if (token_in.count == swks_pkg::RANK_WIDTH'(1)) begin
            token_in_next.found = 1'b1;
            token_in_next.value = value_ff;
         end else begin
            token_in_next.count = token_in.count - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

// ===== rtl/sliding_window_kth_smallest_unit.sv =====
// Top level of the sliding window rank-order filter.
//
//   channel  port     direction  contents
//   req      req_ch   in         sample_value, rank
//   rsp      rsp_ch   out        kth_value, rank_invalid
//   csr      csr_ch   in         window_length
//
// An item that gives no result goes from idle to update and back; an item that gives a
// result also goes through launch, query and drain, the query token stepping one cell a
// cycle along the row. The sorted row is updated in the cycle after the history RAM read.
// Reset empties the row and clears the pointer and fill count; the RAM needs no
// clearing. A stalled result waits in the output register while the next item runs.
`timescale 1ns / 1ps
`include "sliding_window_kth_smallest_unit_assert.svh"

module sliding_window_kth_smallest_unit (
   input  logic        clock,
   input  logic        reset,
   swks_req_if.sink    req_ch,
   swks_rsp_if.source  rsp_ch,
   swks_csr_if.sink    csr_ch
);

   swks_pkg::state_type     state_ff, state_in;
   swks_pkg::len_type       window_length_ff;
   swks_pkg::len_type       len;
   logic [swks_pkg::PTR_WIDTH-1:0] wp_ff, wp_in;
   swks_pkg::len_type       fill_ff, fill_in;
   swks_pkg::sample_type    new_value_ff;
   swks_pkg::rank_type      rank_ff;
   swks_pkg::sample_type    pend_value_ff;
   logic                    pend_invalid_ff;
   logic                    rsp_valid_ff;
   swks_pkg::sample_type    rsp_value_ff;
   logic                    rsp_invalid_ff;

   logic                    req_accept;
   logic                    rsp_load;
   logic                    rank_bad;
   logic [swks_pkg::SAMPLE_WIDTH-1:0] old_raw;
   swks_pkg::cell_ctrl_type ctrl;
   swks_pkg::token_type     launch_token;
   swks_pkg::cell_view_type views [swks_pkg::MAX_WINDOW];
   swks_pkg::token_type     tokens [swks_pkg::MAX_WINDOW+1];

   // Configuration register; writes must arrive only while the block is idle, which the block does not enforce.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= swks_pkg::LEN_WIDTH'(swks_pkg::MAX_WINDOW);
      end else if (csr_ch.valid) begin
         window_length_ff <= csr_ch.window_length;
      end
   end

   // Effective window length: zero reads as one, oversize saturates.
   always_comb begin
      if (window_length_ff == '0) begin
         len = swks_pkg::LEN_WIDTH'(1);
      end else if (window_length_ff > swks_pkg::LEN_WIDTH'(swks_pkg::MAX_WINDOW)) begin
         len = swks_pkg::LEN_WIDTH'(swks_pkg::MAX_WINDOW);
      end else begin
         len = window_length_ff;
      end
   end

   assign req_ch.ready = (state_ff == swks_pkg::ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   // History RAM: the entry read at the write pointer is the sample about to leave.
   swks_ram #(
      .WIDTH (swks_pkg::SAMPLE_WIDTH),
      .DEPTH (swks_pkg::MAX_WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (state_ff == swks_pkg::ST_UPDATE),
      .wr_addr (wp_ff),
      .wr_data (new_value_ff),
      .rd_en   (req_accept),
      .rd_addr (wp_ff),
      .rd_data (old_raw)
   );

   // Broadcast to the row.
   assign ctrl = '{
      update:    (state_ff == swks_pkg::ST_UPDATE),
      evict:     (fill_ff == swks_pkg::LEN_WIDTH'(swks_pkg::MAX_WINDOW)),
      new_value: new_value_ff,
      old_value: $signed(old_raw),
      len:       len
   };

   // Token entering the first cell.
   assign launch_token = '{
      valid: (state_ff == swks_pkg::ST_LAUNCH),
      count: rank_ff,
      found: 1'b0,
      value: '0
   };
   assign tokens[0] = launch_token;

   // Row of cells.
   for (genvar i = 0; i < swks_pkg::MAX_WINDOW; i++) begin : g_cell
      swks_pkg::cell_view_type left_view;
      swks_pkg::cell_view_type right_view;

      if (i == 0) begin : g_left_edge
         assign left_view = swks_pkg::VIEW_LEFT_EDGE;
      end else begin : g_left_inner
         assign left_view = views[i-1];
      end

      if (i == swks_pkg::MAX_WINDOW - 1) begin : g_right_edge
         assign right_view = swks_pkg::VIEW_RIGHT_EDGE;
      end else begin : g_right_inner
         assign right_view = views[i+1];
      end

      swks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_view  (left_view),
         .right_view (right_view),
         .own_view   (views[i]),
         .token_in   (tokens[i]),
         .token_out  (tokens[i+1])
      );
   end

   assign rank_bad = (rank_ff == '0) || (rank_ff > len);
   assign rsp_load = (state_ff == swks_pkg::ST_DRAIN) && (!rsp_valid_ff || rsp_ch.ready);

   // Pointer advances once per sample; fill count advances once per sample until it reaches MAX_WINDOW.
   always_comb begin
      wp_in = (wp_ff == swks_pkg::PTR_WIDTH'(swks_pkg::MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
      if (fill_ff == swks_pkg::LEN_WIDTH'(swks_pkg::MAX_WINDOW)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swks_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = swks_pkg::ST_UPDATE;
            end
         end
         swks_pkg::ST_UPDATE: begin
            state_in = (fill_in >= len) ? swks_pkg::ST_LAUNCH : swks_pkg::ST_IDLE;
         end
         swks_pkg::ST_LAUNCH: begin
            state_in = swks_pkg::ST_QUERY;
         end
         swks_pkg::ST_QUERY: begin
            if (tokens[swks_pkg::MAX_WINDOW].valid) begin
               state_in = swks_pkg::ST_DRAIN;
            end
         end
         swks_pkg::ST_DRAIN: begin
            if (rsp_load) begin
               state_in = swks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swks_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swks_pkg::ST_IDLE;
         wp_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == swks_pkg::ST_UPDATE) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
      end
   end

   // Item payload and the result waiting for the output register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         new_value_ff <= req_ch.sample_value;
         rank_ff      <= req_ch.rank;
      end
      if ((state_ff == swks_pkg::ST_QUERY) && tokens[swks_pkg::MAX_WINDOW].valid) begin
         pend_value_ff   <= rank_bad ? '0 : tokens[swks_pkg::MAX_WINDOW].value;
         pend_invalid_ff <= rank_bad;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff   <= pend_value_ff;
         rsp_invalid_ff <= pend_invalid_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kth_value    = rsp_value_ff;
   assign rsp_ch.rank_invalid = rsp_invalid_ff;

   // Checks on the sequencer and the result path.
   `SWKS_ASSERT_NEXT(a_accept_starts_update, clock, reset, req_accept, state_ff == swks_pkg::ST_UPDATE, "accepted transaction did not start an update")
   `SWKS_ASSERT_SAME(a_token_exit_in_query, clock, reset, tokens[swks_pkg::MAX_WINDOW].valid, state_ff == swks_pkg::ST_QUERY, "query token left the row outside the query state")
   `SWKS_ASSERT_SAME(a_result_from_drain, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == swks_pkg::ST_DRAIN, "result appeared without a drain step")
   `SWKS_ASSERT_SAME(a_invalid_is_zero, clock, reset, rsp_valid_ff && rsp_invalid_ff, rsp_value_ff == '0, "invalid rank gave a non-zero value")

endmodule
